>>> design/bmp_stream_decoder_macros.svh
// Assertion macros shared by the BMP stream decoder RTL.
// No dependencies; included by modules that carry assertions.
`ifndef BMP_STREAM_DECODER_MACROS_SVH
`define BMP_STREAM_DECODER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define BMP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked at the next clock edge, outside reset.
`define BMP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bmp_pkg.sv
// Package for the BMP stream decoder: phase enum, codes, limits, result type.
// No dependencies.
package bmp_pkg;

  localparam int unsigned MAX_DIMENSION     = 10000;
  localparam int unsigned PALETTE_DEPTH     = 256;
  localparam int unsigned MAX_PALETTE_BYTES = 2000;
  localparam int unsigned HDR_LEN           = 54;
  localparam int unsigned HDR_KEEP          = 34;
  localparam int unsigned INFO_SIZE         = 40;
  localparam int unsigned FILE_HDR_SIZE     = 14;

  localparam int unsigned PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned PAL_W  = 24;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_SKIP, PH_PALETTE, PH_PIXELS, PH_DONE
  } phase_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [1:0] ERR_HEADER  = 2'd0;
  localparam logic [1:0] ERR_DEPTH   = 2'd1;
  localparam logic [1:0] ERR_PALETTE = 2'd2;

  // One result beat before the palette color is merged in
  typedef struct packed {
    logic        kind;
    logic [1:0]  error_code;
    logic [13:0] column;
    logic [13:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  palette_index;
    logic        last;
    logic        use_pal;
  } res_t;

endpackage

>>> design/bmp_palette_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the palette store.
module bmp_palette_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/bmp_stream_decoder.sv
// BMP stream decoder: takes one file byte per beat and gives pixel beats or one error beat.
// Depends on bmp_pkg, bmp_palette_ram and bmp_stream_decoder_macros.svh.
//
// The decoder takes one input byte every cycle, with no gaps, for as long as the
// output side keeps up. A result passes from its byte through the decode stage
// register, loaded as the palette RAM read is issued, and then the output register.
// For 8 bpp images the color comes from a 256 x 24 palette RAM with one read port;
// that port is read for every accepted byte. Palette entries carry valid flags that the
// first byte of each file clears at once, so a new file needs no clearing pass.
module bmp_stream_decoder
  import bmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        start_of_file,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [1:0]  error_code,
  output logic [13:0] column,
  output logic [13:0] row,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  palette_index,
  output logic        last
);

  `include "bmp_stream_decoder_macros.svh"

  // Parser state
  phase_t      phase, phase_next;
  logic [31:0] cnt, cnt_next;
  logic [31:0] pal_bytes;
  logic [8:0]  ents, ents_next;
  logic [13:0] img_w, img_w_next;
  logic [13:0] img_h, img_h_next;
  logic        d24, d24_next;
  logic [13:0] col, col_next;
  logic [13:0] row_out, row_out_next;
  logic [15:0] rbc, rbc_next;
  logic [1:0]  sub, sub_next;
  logic [7:0]  cb0, cb0_next;
  logic [7:0]  cb1, cb1_next;
  logic [15:0] row_len, row_len_next;
  logic [15:0] act_len, act_len_next;
  logic [7:0]  hb [HDR_KEEP];

  logic [PALETTE_DEPTH-1:0] pal_vld;

  // Stage and output registers
  logic        p_valid;
  res_t        p_res;
  logic        p_hit;
  logic        move;
  logic        accept;

  // Decode outputs
  logic        emit;
  res_t        res;
  logic        pal_we;
  logic [PAL_AW-1:0] pal_wa;
  logic [PAL_W-1:0]  pal_rd;

  assign move   = !out_valid || out_ready;
  assign in_ready = !p_valid || move;
  assign accept = in_valid && in_ready;

  // Header fields seen through the latched header bytes
  logic [31:0] h_po, h_hs, h_w, h_h, h_comp;
  logic [15:0] h_planes, h_bits;
  assign h_po     = {hb[13], hb[12], hb[11], hb[10]};
  assign h_hs     = {hb[17], hb[16], hb[15], hb[14]};
  assign h_w      = {hb[21], hb[20], hb[19], hb[18]};
  assign h_h      = {hb[25], hb[24], hb[23], hb[22]};
  assign h_planes = {hb[27], hb[26]};
  assign h_bits   = {hb[29], hb[28]};
  assign h_comp   = {hb[33], hb[32], hb[31], hb[30]};

  // Byte decode: next parser state and at most one result
  always_comb begin
    phase_t      cur;
    logic [31:0] c;
    logic [13:0] sw, sh;
    logic        dep24;
    logic [15:0] w3;
    phase_next   = phase;
    cnt_next     = cnt;
    ents_next    = ents;
    img_w_next   = img_w;
    img_h_next   = img_h;
    d24_next     = d24;
    col_next     = col;
    row_out_next = row_out;
    rbc_next     = rbc;
    sub_next     = sub;
    cb0_next     = cb0;
    cb1_next     = cb1;
    row_len_next = row_len;
    act_len_next = act_len;
    emit   = 1'b0;
    res    = '0;
    pal_we = 1'b0;
    pal_wa = cnt[PAL_AW+1:2];
    cur    = start_of_file ? PH_HEADER : phase;
    c      = start_of_file ? 32'd0 : cnt;
    sw     = img_w;
    sh     = img_h;
    dep24  = d24;
    w3     = 16'd0;

    unique case (cur)
      PH_HEADER: begin
        cnt_next = c + 32'd1;
        if (c == 32'(HDR_LEN - 1)) begin
          sw    = h_w[13:0];
          sh    = h_h[13:0];
          dep24 = (h_bits == 16'd24);
          w3    = 16'(sw) + {1'b0, sw, 1'b0};
          img_w_next   = sw;
          img_h_next   = sh;
          d24_next     = dep24;
          ents_next    = (pal_bytes[31:10] != '0) ? 9'(PALETTE_DEPTH)
                                                  : {1'b0, pal_bytes[9:2]};
          row_len_next = dep24 ? ((w3 + 16'd3) & ~16'd3) : ((16'(sw) + 16'd3) & ~16'd3);
          act_len_next = dep24 ? w3 : 16'(sw);
          if (hb[0] != SIG_B || hb[1] != SIG_M || h_hs < 32'(INFO_SIZE) ||
              h_w > 32'(MAX_DIMENSION) || h_h > 32'(MAX_DIMENSION) ||
              h_planes != 16'd1 || h_comp != 32'd0) begin
            emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_HEADER;
            phase_next = PH_DONE;
          end else if (h_bits != 16'd8 && h_bits != 16'd24) begin
            emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_DEPTH;
            phase_next = PH_DONE;
          end else if (!dep24 && (pal_bytes < 32'd4 ||
                                  pal_bytes > 32'(MAX_PALETTE_BYTES))) begin
            emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_PALETTE;
            phase_next = PH_DONE;
          end else if (h_hs != 32'(INFO_SIZE)) begin
            cnt_next   = h_hs - 32'(INFO_SIZE);
            phase_next = PH_SKIP;
          end else begin
            cnt_next   = 32'd0;
            phase_next = dep24 ? PH_PIXELS : PH_PALETTE;
          end
        end else begin
          phase_next = PH_HEADER;
        end
      end
      PH_SKIP: begin
        cnt_next = c - 32'd1;
        if (c == 32'd1) begin
          cnt_next   = 32'd0;
          phase_next = dep24 ? PH_PIXELS : PH_PALETTE;
        end
      end
      PH_PALETTE: begin
        if ({2'b00, c[31:2]} < {23'd0, ents} && c[1:0] != 2'd3) begin
          case (c[1:0])
            2'd0:    cb0_next = data_byte;
            2'd1:    cb1_next = data_byte;
            default: pal_we = 1'b1;
          endcase
        end
        cnt_next = c + 32'd1;
        if (c + 32'd1 >= pal_bytes) begin
          phase_next = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (rbc < act_len) begin
          res.column = col;
          res.row    = row_out;
          res.last   = (row_out == 14'd0) && (col + 14'd1 == img_w);
          if (d24) begin
            case (sub)
              2'd0: begin cb0_next = data_byte; sub_next = 2'd1; end
              2'd1: begin cb1_next = data_byte; sub_next = 2'd2; end
              default: begin
                emit = 1'b1;
                res.red = data_byte; res.green = cb1; res.blue = cb0;
                col_next = col + 14'd1;
                sub_next = 2'd0;
              end
            endcase
          end else begin
            emit = 1'b1;
            res.palette_index = data_byte;
            res.use_pal = 1'b1;
            col_next = col + 14'd1;
          end
        end
        rbc_next = rbc + 16'd1;
        if (rbc + 16'd1 == row_len) begin
          rbc_next     = 16'd0;
          col_next     = 14'd0;
          sub_next     = 2'd0;
          row_out_next = row_out - 14'd1;
          if (row_out == 14'd0) begin
            phase_next = PH_DONE;
          end
        end
      end
      default: ;
    endcase

    // Entry into the pixel walk
    if (phase_next == PH_PIXELS && cur != PH_PIXELS) begin
      col_next     = 14'd0;
      row_out_next = sh - 14'd1;
      rbc_next     = 16'd0;
      sub_next     = 2'd0;
      if (sw == 14'd0 || sh == 14'd0) begin
        phase_next = PH_DONE;
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pal_bytes <= h_po - (h_hs + 32'(FILE_HDR_SIZE));
    if (accept) begin
      if (start_of_file || (phase == PH_HEADER && cnt < 32'(HDR_KEEP))) begin
        hb[start_of_file ? 6'd0 : cnt[5:0]] <= data_byte;
      end
      ents    <= ents_next;
      img_w   <= img_w_next;
      img_h   <= img_h_next;
      d24     <= d24_next;
      col     <= col_next;
      row_out <= row_out_next;
      rbc     <= rbc_next;
      sub     <= sub_next;
      cb0     <= cb0_next;
      cb1     <= cb1_next;
      row_len <= row_len_next;
      act_len <= act_len_next;
    end
  end

  // Palette entry valid flags, dropped at the first byte of each file
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_vld <= '0;
    end else if (accept) begin
      if (start_of_file) begin
        pal_vld <= '0;
      end else if (pal_we) begin
        pal_vld[pal_wa] <= 1'b1;
      end
    end
  end

  bmp_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .WIDTH (PAL_W)
  ) u_pal (
    .clk     (clk),
    .wr_en   (accept && pal_we),
    .wr_addr (pal_wa),
    .wr_data ({data_byte, cb1, cb0}),
    .rd_en   (accept),
    .rd_addr (data_byte[PAL_AW-1:0]),
    .rd_data (pal_rd)
  );

  // Decode stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= emit;
    end else if (move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_res <= res;
      p_hit <= pal_vld[data_byte[PAL_AW-1:0]];
    end
  end

  // Output register, merges palette color
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move && p_valid) begin
      kind          <= p_res.kind;
      error_code    <= p_res.error_code;
      column        <= p_res.column;
      row           <= p_res.row;
      palette_index <= p_res.palette_index;
      last          <= p_res.last;
      if (p_res.use_pal) begin
        red   <= p_hit ? pal_rd[23:16] : 8'd0;
        green <= p_hit ? pal_rd[15:8]  : 8'd0;
        blue  <= p_hit ? pal_rd[7:0]   : 8'd0;
      end else begin
        red   <= p_res.red;
        green <= p_res.green;
        blue  <= p_res.blue;
      end
    end
  end

  // Checks
  `BMP_ASSERT_IMP(a_stall_blocks, clk, rst, p_valid && !move, !in_ready,
    "decode stage overwritten while stalled")
  `BMP_ASSERT_IMP(a_err_clean, clk, rst, out_valid && kind == KIND_ERROR,
    column == 14'd0 && row == 14'd0 && last == 1'b0, "error beat carries pixel data")
  `BMP_ASSERT_IMP(a_last_top, clk, rst, out_valid && kind == KIND_PIXEL && last,
    row == 14'd0, "last pixel not on top row")
  `BMP_ASSERT_NEXT(a_done_quiet, clk, rst, accept && phase == PH_DONE && !start_of_file,
    !p_valid, "result after image end")

endmodule
